/* sv/cfd_pkg.sv */
`default_nettype none

package cfd_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned PROD_W  = 29;
  localparam int unsigned A_W     = 32;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned DIV_NW  = MAG_W + 12;
  localparam int unsigned DIV_DW  = MAG_W;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic pt_acc;
    logic check;
    logic div_phase;
    logic scan_init;
    logic scan_step;
    logic mag_abs;
    logic sq_a;
    logic sq_b;
    logic sqrt_init;
    logic sqrt_step;
    logic mag_store;
    logic zero_check;
    logic div_ratio;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic final_pt;
    logic err;
    logic scan_last;
    logic pipe_busy;
    logic div_done;
    logic sqrt_done;
    logic k_last;
    logic ok;
    logic out_free;
  } sts_t;

  // Q1.15 sine of a 16-bit turn fraction, evaluated at elaboration time.
  function automatic logic signed [15:0] sine_q15(input int unsigned u_in);
    longint unsigned u;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned y;
    longint unsigned y2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q;
    logic signed [15:0] qs;
    u = longint'(u_in) & 64'hFFFF;
    quad = u >> 14;
    r = u & 64'h3FFF;
    if (quad[0]) begin
      r = 64'd16384 - r;
    end
    y = ((r << 16) * PI_HALF_Q30) >> 30;
    y2 = (y * y) >> 30;
    t = Q30_ONE - y2 / 64'd72;
    t = Q30_ONE - ((y2 * t) >> 30) / 64'd42;
    t = Q30_ONE - ((y2 * t) >> 30) / 64'd20;
    t = Q30_ONE - ((y2 * t) >> 30) / 64'd6;
    s = (y * t) >> 30;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    qs = 16'(q);
    return (quad >= 64'd2) ? -qs : qs;
  endfunction

endpackage

`default_nettype wire

/* sv/cfd_ram.sv */
`default_nettype none

module cfd_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/cfd_div.sv */
`default_nettype none

module cfd_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [cfd_pkg::DIV_NW-1:0] num_i,
  input  wire logic [cfd_pkg::DIV_DW-1:0] den_i,
  output logic                           done_o,
  output logic [cfd_pkg::DIV_NW-1:0]     quo_o,
  output logic [cfd_pkg::DIV_DW-1:0]     rem_o
);

  localparam int unsigned NW  = cfd_pkg::DIV_NW;
  localparam int unsigned DW  = cfd_pkg::DIV_DW;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
    end
  end

  assign done_o = !busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* sv/cfd_datapath.sv */
`default_nettype none

module cfd_datapath #(
  parameter int unsigned MAX_POINTS       = 1024,
  parameter int unsigned TOP_HARMONIC     = 13,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfd_pkg::cmd_t        cmd_i,
  output cfd_pkg::sts_t             sts_o,
  input  wire logic [11:0]          point_x_i,
  input  wire logic [11:0]          point_y_i,
  input  wire logic                 final_point_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [3:0]                harmonic_number_o,
  output logic [15:0]               descriptor_ratio_o,
  output logic [11:0]               box_min_x_o,
  output logic [11:0]               box_min_y_o,
  output logic [11:0]               box_max_x_o,
  output logic [11:0]               box_max_y_o,
  output logic [1:0]                shape_status_o,
  output logic                      final_result_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned HK_W   = $clog2(TOP_HARMONIC + 1);
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned SUM_W  = cfd_pkg::PROD_W + 1 + CNT_W;
  localparam int unsigned MIN_PTS = TOP_HARMONIC + 1;
  localparam int unsigned NW     = cfd_pkg::DIV_NW;
  localparam int unsigned DW     = cfd_pkg::DIV_DW;
  localparam int unsigned CW     = cfd_pkg::COORD_W;

  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic [CW-1:0]    min_x_q, min_y_q, max_x_q, max_y_q;
  logic [1:0]       status_q;
  logic [HK_W-1:0]  k_q;
  logic [CNT_W-1:0] j_q;
  logic [CNT_W-1:0] m_q;
  logic [CNT_W-1:0] rem_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] qk_q;
  logic [CNT_W-1:0] rk_q;
  logic             v1_q, v2_q;
  logic signed [cfd_pkg::TRIG_W-1:0] sin_q, cos_q;
  logic signed [cfd_pkg::PROD_W-1:0] p_xc_q, p_ys_q, p_yc_q, p_xs_q;
  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic [cfd_pkg::A_W-1:0]  a_q, b_q;
  logic [cfd_pkg::SQ_W-1:0] sq_q, sv_q, res_q, bit_q;
  logic [cfd_pkg::MAG_W-1:0] mags_q [TOP_HARMONIC + 1];
  logic [cfd_pkg::MAG_W-1:0] mag1_q;
  logic             out_valid_q;
  logic [3:0]       harm_q;
  logic [15:0]      ratio_q;
  logic [CW-1:0]    o_min_x_q, o_min_y_q, o_max_x_q, o_max_y_q;
  logic [1:0]       o_status_q;
  logic             o_final_q;

  logic signed [cfd_pkg::TRIG_W-1:0] sin_rom [SINE_TABLE_DEPTH];
  logic signed [cfd_pkg::TRIG_W-1:0] cos_rom [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam int unsigned U = (gi * 65536) / SINE_TABLE_DEPTH;
    assign sin_rom[gi] = cfd_pkg::sine_q15(U);
    assign cos_rom[gi] = cfd_pkg::sine_q15(U + 16384);
  end

  logic          full;
  logic [CW-1:0] x_rd, y_rd;

  assign full = count_q >= CNT_W'(MAX_POINTS);

  cfd_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pt_acc && !full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (point_x_i),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (x_rd)
  );

  cfd_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pt_acc && !full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (point_y_i),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (y_rd)
  );

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den, div_rem;

  assign div_start = cmd_i.div_phase || cmd_i.div_ratio;
  assign div_num = cmd_i.div_phase ? NW'(k_q) * NW'(SINE_TABLE_DEPTH)
                                   : {mags_q[k_q], 12'b0};
  assign div_den = cmd_i.div_phase ? DW'(count_q) : mag1_q;

  cfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  logic [CNT_W:0]   m_sum, r_sum, n_ext;
  logic             m_wrap, r_wrap;
  logic [IDX_W+1:0] i_sum;
  logic [CNT_W-1:0] m_next, rem_next;
  logic [IDX_W-1:0] idx_next;

  always_comb begin
    n_ext    = (CNT_W + 1)'(count_q);
    m_sum    = (CNT_W + 1)'(m_q) + (CNT_W + 1)'(k_q);
    r_sum    = (CNT_W + 1)'(rem_q) + (CNT_W + 1)'(rk_q);
    r_wrap   = r_sum >= n_ext;
    m_wrap   = m_sum >= n_ext;
    i_sum    = (IDX_W + 2)'(idx_q) + (IDX_W + 2)'(qk_q) + (IDX_W + 2)'(r_wrap);
    m_next   = m_wrap ? CNT_W'(m_sum - n_ext) : CNT_W'(m_sum);
    rem_next = r_wrap ? CNT_W'(r_sum - n_ext) : CNT_W'(r_sum);
    idx_next = m_wrap ? IDX_W'(i_sum - (IDX_W + 2)'(SINE_TABLE_DEPTH)) : IDX_W'(i_sum);
  end

  logic [SUM_W-1:0] abs_x, abs_y;
  logic [SUM_W-1:0] rnd_x, rnd_y;
  logic [cfd_pkg::SQ_W-1:0] sq_try;
  logic [15:0] ratio_sat;

  assign abs_x  = sx_q[SUM_W-1] ? SUM_W'(-sx_q) : SUM_W'(sx_q);
  assign abs_y  = sy_q[SUM_W-1] ? SUM_W'(-sy_q) : SUM_W'(sy_q);
  assign rnd_x  = (abs_x + SUM_W'(1024)) >> 11;
  assign rnd_y  = (abs_y + SUM_W'(1024)) >> 11;
  assign sq_try = res_q + bit_q;
  assign ratio_sat = (|div_quo[NW-1:16]) ? 16'hFFFF : div_quo[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      min_x_q     <= '1;
      min_y_q     <= '1;
      max_x_q     <= '0;
      max_y_q     <= '0;
      status_q    <= cfd_pkg::ST_OK;
      k_q         <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pt_acc) begin
        if (point_x_i < min_x_q) min_x_q <= point_x_i;
        if (point_y_i < min_y_q) min_y_q <= point_y_i;
        if (point_x_i > max_x_q) max_x_q <= point_x_i;
        if (point_y_i > max_y_q) max_y_q <= point_y_i;
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        min_x_q <= '1;
        min_y_q <= '1;
        max_x_q <= '0;
        max_y_q <= '0;
      end
      if (cmd_i.check) begin
        k_q <= HK_W'(1);
        if (ovf_q) begin
          status_q <= cfd_pkg::ST_OVF;
        end else if (count_q < CNT_W'(MIN_PTS)) begin
          status_q <= cfd_pkg::ST_FEW;
        end else begin
          status_q <= cfd_pkg::ST_OK;
        end
      end
      if (cmd_i.zero_check) begin
        k_q <= HK_W'(2);
        if (status_q == cfd_pkg::ST_OK && mag1_q == '0) begin
          status_q <= cfd_pkg::ST_ZERO;
        end
      end
      if (cmd_i.mag_store || cmd_i.out_load) begin
        k_q <= k_q + HK_W'(1);
      end
      if (cmd_i.scan_init) begin
        j_q <= '0;
      end else if (cmd_i.scan_step) begin
        j_q <= j_q + CNT_W'(1);
      end
      v1_q <= cmd_i.scan_step;
      v2_q <= v1_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      m_q   <= '0;
      rem_q <= '0;
      idx_q <= '0;
      qk_q  <= div_quo[IDX_W-1:0];
      rk_q  <= div_rem[CNT_W-1:0];
      sx_q  <= '0;
      sy_q  <= '0;
    end else begin
      if (cmd_i.scan_step) begin
        m_q   <= m_next;
        rem_q <= rem_next;
        idx_q <= idx_next;
      end
      if (v2_q) begin
        sx_q <= sx_q + SUM_W'(p_xc_q) + SUM_W'(p_ys_q);
        sy_q <= sy_q + SUM_W'(p_yc_q) - SUM_W'(p_xs_q);
      end
    end
    sin_q  <= sin_rom[idx_q];
    cos_q  <= cos_rom[idx_q];
    p_xc_q <= $signed({1'b0, x_rd}) * cos_q;
    p_ys_q <= $signed({1'b0, y_rd}) * sin_q;
    p_yc_q <= $signed({1'b0, y_rd}) * cos_q;
    p_xs_q <= $signed({1'b0, x_rd}) * sin_q;
    if (cmd_i.mag_abs) begin
      a_q <= cfd_pkg::A_W'(rnd_x);
      b_q <= cfd_pkg::A_W'(rnd_y);
    end
    if (cmd_i.sq_a) begin
      sq_q <= cfd_pkg::SQ_W'(a_q) * cfd_pkg::SQ_W'(a_q);
    end else if (cmd_i.sq_b) begin
      sq_q <= sq_q + cfd_pkg::SQ_W'(b_q) * cfd_pkg::SQ_W'(b_q);
    end
    if (cmd_i.sqrt_init) begin
      sv_q  <= sq_q;
      res_q <= '0;
      bit_q <= cfd_pkg::SQ_W'(1) << 62;
    end else if (cmd_i.sqrt_step) begin
      if (sv_q >= sq_try) begin
        sv_q  <= sv_q - sq_try;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.mag_store) begin
      mags_q[k_q] <= res_q[cfd_pkg::MAG_W-1:0];
      if (k_q == HK_W'(1)) begin
        mag1_q <= res_q[cfd_pkg::MAG_W-1:0];
      end
    end
    if (cmd_i.out_load) begin
      harm_q     <= 4'(k_q);
      ratio_q    <= (status_q == cfd_pkg::ST_OK) ? ratio_sat : 16'd0;
      o_min_x_q  <= min_x_q;
      o_min_y_q  <= min_y_q;
      o_max_x_q  <= max_x_q;
      o_max_y_q  <= max_y_q;
      o_status_q <= status_q;
      o_final_q  <= k_q == HK_W'(TOP_HARMONIC);
    end
  end

  always_comb begin
    sts_o.final_pt  = final_point_i;
    sts_o.err       = ovf_q || (count_q < CNT_W'(MIN_PTS));
    sts_o.scan_last = (j_q + CNT_W'(1)) == count_q;
    sts_o.pipe_busy = v1_q || v2_q;
    sts_o.div_done  = div_done;
    sts_o.sqrt_done = bit_q == '0;
    sts_o.k_last    = k_q == HK_W'(TOP_HARMONIC);
    sts_o.ok        = status_q == cfd_pkg::ST_OK;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o        = out_valid_q;
  assign harmonic_number_o  = harm_q;
  assign descriptor_ratio_o = ratio_q;
  assign box_min_x_o        = o_min_x_q;
  assign box_min_y_o        = o_min_y_q;
  assign box_max_x_o        = o_max_x_q;
  assign box_max_y_o        = o_max_y_q;
  assign shape_status_o     = o_status_q;
  assign final_result_o     = o_final_q;

endmodule

`default_nettype wire

/* sv/cfd_ctrl.sv */
`default_nettype none

module cfd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cfd_pkg::sts_t sts_i,
  output cfd_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_CHECK, S_PH_DIV, S_PH_WAIT, S_SCAN, S_DRAIN, S_ABS, S_SQ_A,
    S_SQ_B, S_SQ_INIT, S_SQRT, S_STORE, S_ZCHK, S_EMIT, S_RAT_WAIT, S_PUT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.pt_acc = 1'b1;
          if (sts_i.final_pt) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = sts_i.err ? S_ZCHK : S_PH_DIV;
      end
      S_PH_DIV: begin
        cmd_o.div_phase = 1'b1;
        state_d = S_PH_WAIT;
      end
      S_PH_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = S_ABS;
      end
      S_ABS: begin
        cmd_o.mag_abs = 1'b1;
        state_d = S_SQ_A;
      end
      S_SQ_A: begin
        cmd_o.sq_a = 1'b1;
        state_d = S_SQ_B;
      end
      S_SQ_B: begin
        cmd_o.sq_b = 1'b1;
        state_d = S_SQ_INIT;
      end
      S_SQ_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_STORE;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      S_STORE: begin
        cmd_o.mag_store = 1'b1;
        state_d = sts_i.k_last ? S_ZCHK : S_PH_DIV;
      end
      S_ZCHK: begin
        cmd_o.zero_check = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.ok) begin
          cmd_o.div_ratio = 1'b1;
          state_d = S_RAT_WAIT;
        end else begin
          state_d = S_PUT;
        end
      end
      S_RAT_WAIT: begin
        if (sts_i.div_done) state_d = S_PUT;
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.clear = 1'b1;
            state_d = S_LOAD;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  assign in_ready_o = state_q == S_LOAD;

endmodule

`default_nettype wire

/* sv/contour_fourier_descriptor.sv */
// Channel | Direction | Fields
// in      | request   | point_x, point_y, final_point
// out     | result    | harmonic_number, descriptor_ratio, box_*, shape_status, final_result
//
// Points load at one per cycle until the flagged final point.
// For each harmonic of a valid contour, the shared divider then sets the phase step,
// the stored points stream through one multiply-add pipeline, and a 32-step integer
// root forms the magnitude.
// Each of the twelve results then passes through the same divider, or skips it in error.
// Reset is asynchronous and needs no clearing pass; a stalled output holds the block.
`default_nettype none

module contour_fourier_descriptor #(
  parameter int unsigned MAX_POINTS       = 1024,
  parameter int unsigned TOP_HARMONIC     = 13,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [11:0] point_x_i,
  input  wire logic [11:0] point_y_i,
  input  wire logic        final_point_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       harmonic_number_o,
  output logic [15:0]      descriptor_ratio_o,
  output logic [11:0]      box_min_x_o,
  output logic [11:0]      box_min_y_o,
  output logic [11:0]      box_max_x_o,
  output logic [11:0]      box_max_y_o,
  output logic [1:0]       shape_status_o,
  output logic             final_result_o
);

  cfd_pkg::cmd_t cmd;
  cfd_pkg::sts_t sts;

  cfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfd_datapath #(
    .MAX_POINTS       (MAX_POINTS),
    .TOP_HARMONIC     (TOP_HARMONIC),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .final_point_i      (final_point_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .harmonic_number_o  (harmonic_number_o),
    .descriptor_ratio_o (descriptor_ratio_o),
    .box_min_x_o        (box_min_x_o),
    .box_min_y_o        (box_min_y_o),
    .box_max_x_o        (box_max_x_o),
    .box_max_y_o        (box_max_y_o),
    .shape_status_o     (shape_status_o),
    .final_result_o     (final_result_o)
  );

endmodule

`default_nettype wire

/* sv/cfd_checker.sv */
`default_nettype none

module cfd_checker #(
  parameter int unsigned TOP_HARMONIC = 13
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        final_point_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  harmonic_number_o,
  input wire logic [15:0] descriptor_ratio_o,
  input wire logic [11:0] box_min_x_o,
  input wire logic [11:0] box_min_y_o,
  input wire logic [11:0] box_max_x_o,
  input wire logic [11:0] box_max_y_o,
  input wire logic [1:0]  shape_status_o,
  input wire logic        final_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(descriptor_ratio_o)
      && $stable(harmonic_number_o))
    else $error("stalled result changed");

  a_last_harm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_result_o |-> harmonic_number_o == 4'(TOP_HARMONIC))
    else $error("last result carries wrong harmonic");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shape_status_o != cfd_pkg::ST_OK |-> descriptor_ratio_o == 16'd0)
    else $error("error result with nonzero ratio");

  a_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> box_min_x_o <= box_max_x_o && box_min_y_o <= box_max_y_o)
    else $error("bounding box inverted");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_point_i |=> !in_ready_o)
    else $error("point taken after contour end");

endmodule

bind contour_fourier_descriptor cfd_checker #(.TOP_HARMONIC(TOP_HARMONIC)) u_cfd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .final_point_i      (final_point_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .harmonic_number_o  (harmonic_number_o),
  .descriptor_ratio_o (descriptor_ratio_o),
  .box_min_x_o        (box_min_x_o),
  .box_min_y_o        (box_min_y_o),
  .box_max_x_o        (box_max_x_o),
  .box_max_y_o        (box_max_y_o),
  .shape_status_o     (shape_status_o),
  .final_result_o     (final_result_o)
);

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  harmonic;
    logic [15:0] ratio;
    logic [11:0] min_x;
    logic [11:0] min_y;
    logic [11:0] max_x;
    logic [11:0] max_y;
    logic [1:0]  status;
    logic        last;
  } descriptor_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] point_x_i = '0;
  logic [11:0] point_y_i = '0;
  logic        final_point_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  harmonic_number_o;
  logic [15:0] descriptor_ratio_o;
  logic [11:0] box_min_x_o;
  logic [11:0] box_min_y_o;
  logic [11:0] box_max_x_o;
  logic [11:0] box_max_y_o;
  logic [1:0]  shape_status_o;
  logic        final_result_o;

  contour_fourier_descriptor uut (.*);

  always #5 clk_i = ~clk_i;

  descriptor_t pending_descriptors[$];
  int unsigned fail_count = 0;
  logic signed [15:0] sine_lut[1024];
  logic [11:0] stored_x[1024];
  logic [11:0] stored_y[1024];
  int unsigned stored_count = 0;
  bit          store_overflow = 0;
  logic [11:0] lo_x = 12'hFFF, lo_y = 12'hFFF, hi_x = 12'h000, hi_y = 12'h000;
  bit          no_gaps = 0;
  int unsigned ready_hold = 0;

  function automatic logic signed [15:0] q15_sine(longint unsigned turn);
    longint unsigned quad, r, y, y2, t, s, q;
    turn = turn & 64'hFFFF;
    quad = turn >> 14;
    r = turn & 64'h3FFF;
    if (quad[0]) begin
      r = 64'd16384 - r;
    end
    y = ((r << 16) * 64'd1686629713) >> 30;
    y2 = (y * y) >> 30;
    t = 64'd1073741824 - y2 / 72;
    t = 64'd1073741824 - ((y2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((y2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((y2 * t) >> 30) / 6;
    s = (y * t) >> 30;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return (quad >= 2) ? -16'(q) : 16'(q);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] harmonic_size(int unsigned k, int unsigned n);
    longint signed sx, sy, cs, sn;
    longint unsigned a, b;
    int unsigned m, idx;
    sx = 0;
    sy = 0;
    for (int unsigned j = 0; j < n; j++) begin
      m = (k * j) % n;
      idx = (m * 1024) / n;
      sn = sine_lut[idx];
      cs = sine_lut[(idx + 256) % 1024];
      sx += longint'(stored_x[j]) * cs + longint'(stored_y[j]) * sn;
      sy += longint'(stored_y[j]) * cs - longint'(stored_x[j]) * sn;
    end
    a = ((sx < 0) ? -sx : sx);
    b = ((sy < 0) ? -sy : sy);
    a = (a + 1024) >> 11;
    b = (b + 1024) >> 11;
    return 32'(int_root(a * a + b * b));
  endfunction

  task automatic predict_point(logic [11:0] x, logic [11:0] y, logic fin);
    logic [31:0] mags[14];
    logic [1:0] status;
    longint unsigned ratio;
    descriptor_t d;
    if (x < lo_x) lo_x = x;
    if (y < lo_y) lo_y = y;
    if (x > hi_x) hi_x = x;
    if (y > hi_y) hi_y = y;
    if (stored_count < 1024) begin
      stored_x[stored_count] = x;
      stored_y[stored_count] = y;
      stored_count++;
    end else begin
      store_overflow = 1;
    end
    if (fin) begin
      status = cfd_pkg::ST_OK;
      if (store_overflow) begin
        status = cfd_pkg::ST_OVF;
      end else if (stored_count < 14) begin
        status = cfd_pkg::ST_FEW;
      end else begin
        for (int k = 1; k <= 13; k++) mags[k] = harmonic_size(k, stored_count);
        if (mags[1] == 0) status = cfd_pkg::ST_ZERO;
      end
      for (int k = 2; k <= 13; k++) begin
        ratio = 0;
        if (status == cfd_pkg::ST_OK) begin
          ratio = (longint'(mags[k]) << 12) / mags[1];
          if (ratio > 65535) ratio = 65535;
        end
        d.harmonic = 4'(k);
        d.ratio = 16'(ratio);
        d.min_x = lo_x;
        d.min_y = lo_y;
        d.max_x = hi_x;
        d.max_y = hi_y;
        d.status = status;
        d.last = (k == 13);
        pending_descriptors = {pending_descriptors, d};
      end
      stored_count = 0;
      store_overflow = 0;
      lo_x = 12'hFFF;
      lo_y = 12'hFFF;
      hi_x = 12'h000;
      hi_y = 12'h000;
    end
  endtask

  function automatic int unsigned pick_gap();
    if (no_gaps || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(logic [11:0] x, logic [11:0] y, logic fin);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    final_point_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    predict_point(x, y, fin);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_descriptors.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_contour(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_point(12'($urandom), 12'($urandom), i == n - 1);
    end
  endtask

  task automatic test_short_contours();
    send_point(12'd0, 12'd4095, 1'b1);
    send_random_contour(13);
    send_random_contour(14);
  endtask

  task automatic test_extreme_box();
    for (int i = 0; i < 16; i++) begin
      send_point((i % 2) ? 12'hFFF : 12'h000, (i % 4 < 2) ? 12'h000 : 12'hFFF, i == 15);
    end
  endtask

  task automatic test_flat_contour();
    for (int i = 0; i < 20; i++) send_point(12'd1234, 12'd2345, i == 19);
  endtask

  task automatic test_overflow();
    no_gaps = 1;
    for (int i = 0; i < 1026; i++) send_point(12'($urandom), 12'($urandom), i == 1025);
    no_gaps = 0;
  endtask

  task automatic test_random_contours();
    int unsigned sent, n;
    sent = 0;
    while (sent < 450) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, 13);
        1: n = $urandom_range(60, 120);
        default: n = $urandom_range(14, 40);
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      send_random_contour(n);
      sent += n;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    no_gaps = 0;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 2) begin
      ready_hold = $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      out_ready_i <= ~out_ready_i;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    descriptor_t d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_descriptors.size() == 0) begin
        $error("unexpected result, harmonic %0d", harmonic_number_o);
        fail_count++;
      end else begin
        d = pending_descriptors.pop_front();
        if (harmonic_number_o !== d.harmonic) begin
          $error("harmonic_number expected %0d got %0d", d.harmonic, harmonic_number_o);
          fail_count++;
        end
        if (descriptor_ratio_o !== d.ratio) begin
          $error("descriptor_ratio expected %0d got %0d", d.ratio, descriptor_ratio_o);
          fail_count++;
        end
        if (box_min_x_o !== d.min_x) begin
          $error("box_min_x expected %0d got %0d", d.min_x, box_min_x_o);
          fail_count++;
        end
        if (box_min_y_o !== d.min_y) begin
          $error("box_min_y expected %0d got %0d", d.min_y, box_min_y_o);
          fail_count++;
        end
        if (box_max_x_o !== d.max_x) begin
          $error("box_max_x expected %0d got %0d", d.max_x, box_max_x_o);
          fail_count++;
        end
        if (box_max_y_o !== d.max_y) begin
          $error("box_max_y expected %0d got %0d", d.max_y, box_max_y_o);
          fail_count++;
        end
        if (shape_status_o !== d.status) begin
          $error("shape_status expected %0d got %0d", d.status, shape_status_o);
          fail_count++;
        end
        if (final_result_o !== d.last) begin
          $error("final_result expected %0d got %0d", d.last, final_result_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 1024; i++) sine_lut[i] = q15_sine(longint'(i) * 64);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_short_contours();
    test_extreme_box();
    test_flat_contour();
    wait_drained();
    test_overflow();
    test_random_contours();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[contour_fourier_descriptor] OK");
    end else begin
      $display("[contour_fourier_descriptor] ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("[contour_fourier_descriptor] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
